// ===== hdl/qdia_pkg.sv =====
// Shared types and constants for the quadrature decoder with interval average.
// Holds the phase codes, the step code type and the 4x quadrature step function.
// No dependencies.
package qdia_pkg;

  // Phase select codes carried on mode_i
  localparam logic PHASE_A = 1'b0;
  localparam logic PHASE_B = 1'b1;

  // Position step taken by one edge
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_e;

  // 4x quadrature rule; pair is {A, B}. Repeats and double transitions do not count.
  function automatic step_e quad_step(input logic [1:0] old_pair, input logic [1:0] new_pair);
    logic [3:0] trans;
    step_e      step;
    trans = {old_pair, new_pair};
    if (trans inside {4'b0001, 4'b0111, 4'b1110, 4'b1000}) begin
      step = STEP_UP;
    end else if (trans inside {4'b0010, 4'b1011, 4'b1101, 4'b0100}) begin
      step = STEP_DOWN;
    end else begin
      step = STEP_NONE;
    end
    return step;
  endfunction

endpackage

// ===== hdl/quadrature_decoder_with_interval_average_top.sv =====
// Quadrature decoder (4x) with edge-interval mean; uses qdia_pkg and qdia_mean_div.
// Pipeline: an accepted request loads stage 1; stage 2 and the output register follow.
// Throughput: one request per cycle unless a held result stalls the pipeline; the interval
// ring is a one-port-write, one-port-read memory touched once per request, and the running
// sum closes its loop through sum_q alone.
// Reset: position, levels, prior time, sum and ring index clear; per-entry valid
// bits clear at once so the ring reads as zero. No clearing pass is needed.
module quadrature_decoder_with_interval_average_top #(
  parameter int unsigned SAMPLE_COUNT = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic               rising_edge_i,
  input  logic [31:0]        timestamp_us_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] position_count_o,
  output logic [31:0]        mean_interval_us_o
);

  localparam int unsigned IW   = $clog2(SAMPLE_COUNT);
  localparam int unsigned SumW = 32 + IW;
  localparam logic [IW-1:0] LAST_IDX = IW'(SAMPLE_COUNT - 1);

  logic en;
  logic acc;

  // Front state
  logic          level_a_q, level_b_q;
  logic          level_a_d, level_b_d;
  logic [31:0]   pos_q, pos_d;
  logic [31:0]   prior_q;
  logic [IW-1:0] wr_idx_q;
  qdia_pkg::step_e step;

  // Ring memory and entry valid bits
  logic [31:0]             ring_mem [SAMPLE_COUNT];
  logic [SAMPLE_COUNT-1:0] live_q;
  logic [31:0]             rd_q;

  // Stage 1
  logic          s1_valid_q;
  logic [31:0]   s1_pos_q;
  logic [31:0]   s1_ivl_q;
  logic [IW-1:0] s1_idx_q;
  logic          s1_live_q;
  logic [31:0]   old_ivl;
  logic [SumW-1:0] sum_q, sum_d;

  // Stage 2 and output
  logic          s2_valid_q;
  logic [31:0]   s2_pos_q;
  logic          out_valid_q;
  logic [31:0]   out_pos_q;

  // Whole pipeline moves unless a finished result is held up
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;
  assign acc        = in_valid_i && en;

  // New phase levels and position step
  always_comb begin
    level_a_d = level_a_q;
    level_b_d = level_b_q;
    if (mode_i == qdia_pkg::PHASE_A) begin
      level_a_d = rising_edge_i;
    end else begin
      level_b_d = rising_edge_i;
    end
    step = qdia_pkg::quad_step({level_a_q, level_b_q}, {level_a_d, level_b_d});
    case (step)
      qdia_pkg::STEP_UP:   pos_d = pos_q + 32'd1;
      qdia_pkg::STEP_DOWN: pos_d = pos_q - 32'd1;
      default:             pos_d = pos_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_a_q <= 1'b0;
      level_b_q <= 1'b0;
      pos_q     <= '0;
      prior_q   <= '0;
      wr_idx_q  <= '0;
    end else if (acc) begin
      level_a_q <= level_a_d;
      level_b_q <= level_b_d;
      pos_q     <= pos_d;
      prior_q   <= timestamp_us_i;
      wr_idx_q  <= (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + IW'(1);
    end
  end

  // Ring: read the retiring entry on accept, write the new interval from stage 1
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q <= ring_mem[wr_idx_q];
    end
    if (en && s1_valid_q) begin
      ring_mem[s1_idx_q] <= s1_ivl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else if (en && s1_valid_q) begin
      live_q[s1_idx_q] <= 1'b1;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pos_q  <= pos_d;
      s1_ivl_q  <= timestamp_us_i - prior_q;
      s1_idx_q  <= wr_idx_q;
      s1_live_q <= live_q[wr_idx_q];
    end
  end

  // Running sum: drop the retiring entry, add the new one
  assign old_ivl = s1_live_q ? rd_q : 32'd0;
  assign sum_d   = sum_q - SumW'(old_ivl) + SumW'(s1_ivl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en && s1_valid_q) begin
      sum_q <= sum_d;
    end
  end

  // Valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // Position follows the divider stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_pos_q  <= s1_pos_q;
      out_pos_q <= s2_pos_q;
    end
  end

  qdia_mean_div #(
    .Divisor (SAMPLE_COUNT),
    .SumW    (SumW)
  ) u_mean_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sum_d),
    .mean_o (mean_interval_us_o)
  );

  assign out_valid_o      = out_valid_q;
  assign position_count_o = out_pos_q;

endmodule

// ===== hdl/qdia_mean_div.sv =====
// Divides the running interval sum by the ring depth: a reciprocal multiply
// split into four partial products, then one add and shift, registered as stages A and B.
// Standalone; needs no package.
module qdia_mean_div #(
  parameter int unsigned Divisor = 16,
  parameter int unsigned SumW    = 36
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [SumW-1:0] sum_i,
  output logic [31:0]     mean_o
);

  // floor(x / Divisor) == floor(x * MULT / 2^K) for every x below 2^SumW
  localparam int unsigned LG        = $clog2(Divisor);
  localparam int unsigned K         = SumW + LG;
  localparam int unsigned MW        = SumW + 1;
  localparam logic [63:0] MULT_FULL =
    ((64'd1 << K) + 64'(Divisor) - 64'd1) / 64'(Divisor);
  localparam logic [MW-1:0] MULT    = MULT_FULL[MW-1:0];

  // Operand split points
  localparam int unsigned XLO = SumW / 2;
  localparam int unsigned XHI = SumW - XLO;
  localparam int unsigned MLO = MW / 2;
  localparam int unsigned MHI = MW - MLO;
  localparam int unsigned PW  = SumW + MW;

  localparam logic [MLO-1:0] M_LO = MULT[MLO-1:0];
  localparam logic [MHI-1:0] M_HI = MULT[MW-1:MLO];

  logic [XLO-1:0]     x_lo;
  logic [XHI-1:0]     x_hi;
  logic [XLO+MLO-1:0] pll_q;
  logic [XLO+MHI-1:0] plh_q;
  logic [XHI+MLO-1:0] phl_q;
  logic [XHI+MHI-1:0] phh_q;
  logic [PW-1:0]      prod;
  logic [31:0]        mean_q;

  assign x_lo = sum_i[XLO-1:0];
  assign x_hi = sum_i[SumW-1:XLO];

  // Stage A: partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pll_q <= (XLO+MLO)'(x_lo) * (XLO+MLO)'(M_LO);
      plh_q <= (XLO+MHI)'(x_lo) * (XLO+MHI)'(M_HI);
      phl_q <= (XHI+MLO)'(x_hi) * (XHI+MLO)'(M_LO);
      phh_q <= (XHI+MHI)'(x_hi) * (XHI+MHI)'(M_HI);
    end
  end

  // Stage B: combine and take the quotient bits
  assign prod = PW'(pll_q)
              + (PW'(plh_q) << MLO)
              + (PW'(phl_q) << XLO)
              + (PW'(phh_q) << (XLO + MLO));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mean_q <= prod[K +: 32];
    end
  end

  assign mean_o = mean_q;

endmodule

// ===== tb/quadrature_decoder_with_interval_average_top_tb.sv =====
// Self-checking testbench for quadrature_decoder_with_interval_average_top.
// A tracker class predicts position and mean interval for every accepted request.
// Depends on qdia_pkg and the RTL of the top level with its qdia_mean_div only.
module quadrature_decoder_with_interval_average_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH = 16;
  localparam time         RUN_LIMIT  = 5ms;

  // One report the block gives per edge
  typedef struct packed {
    logic signed [31:0] position;
    logic [31:0]        mean_us;
  } edge_report_t;

  // Tracks encoder state and the interval ring; holds the reports still owed
  class quad_edge_tracker;
    logic               level_a;
    logic               level_b;
    logic [1:0]         last_pair;
    logic signed [31:0] position;
    logic [31:0]        prior_ts;
    logic [31:0]        ring [RING_DEPTH];
    int unsigned        wr_idx;
    logic [39:0]        interval_total;
    edge_report_t       report_q[$];
    int unsigned        errors;

    function new();
      level_a        = 1'b0;
      level_b        = 1'b0;
      last_pair      = 2'b00;
      position       = '0;
      prior_ts       = '0;
      wr_idx         = 0;
      interval_total = '0;
      errors         = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    // Accepted request: update state and queue the report it must produce
    function void note_edge(input logic mode, input logic rise, input logic [31:0] ts);
      logic [1:0]      pair;
      logic [1:0]      old_phase;
      logic [1:0]      new_phase;
      logic [1:0]      phase_diff;
      logic [31:0]     interval;
      qdia_pkg::step_e step;
      edge_report_t    report;
      if (mode == qdia_pkg::PHASE_A) level_a = rise;
      else level_b = rise;
      pair = {level_a, level_b};

      // Gray pair to phase index: 00,01,11,10 -> 0,1,2,3; a distance of two is illegal
      old_phase  = {last_pair[1], ^last_pair};
      new_phase  = {pair[1], ^pair};
      phase_diff = new_phase - old_phase;
      if (phase_diff == 2'd1) step = qdia_pkg::STEP_UP;
      else if (phase_diff == 2'd3) step = qdia_pkg::STEP_DOWN;
      else step = qdia_pkg::STEP_NONE;
      if (step == qdia_pkg::STEP_UP) position = position + 32'sd1;
      else if (step == qdia_pkg::STEP_DOWN) position = position - 32'sd1;
      last_pair = pair;

      // Interval is modular; running total stays exact
      interval       = ts - prior_ts;
      prior_ts       = ts;
      interval_total = interval_total - ring[wr_idx] + interval;
      ring[wr_idx]   = interval;
      wr_idx         = (wr_idx + 1) % RING_DEPTH;

      report.position = position;
      report.mean_us  = 32'(interval_total / RING_DEPTH);
      report_q.push_back(report);
    endfunction

    // Accepted result: compare against the oldest report owed
    function void check_report(input logic signed [31:0] position_got,
                               input logic [31:0] mean_got);
      edge_report_t want;
      if (report_q.size() == 0) begin
        $display("%0t: result with nothing expected: position %0d mean %0d",
                 $time, position_got, mean_got);
        errors++;
        return;
      end
      want = report_q.pop_front();
      if (position_got !== want.position) begin
        $display("%0t: position_count mismatch: expected %0d actual %0d",
                 $time, want.position, position_got);
        errors++;
      end
      if (mean_got !== want.mean_us) begin
        $display("%0t: mean_interval_us mismatch: expected %0d actual %0d",
                 $time, want.mean_us, mean_got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return report_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               mode_i;
  logic               rising_edge_i;
  logic [31:0]        timestamp_us_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] position_count_o;
  logic [31:0]        mean_interval_us_o;

  quad_edge_tracker tracker;

  // Generator state: phase levels as driven, walking direction, time base
  logic        drv_a;
  logic        drv_b;
  logic        walk_fwd;
  logic [31:0] drv_ts;
  logic        send_burst;
  logic        recv_burst;

  quadrature_decoder_with_interval_average_top #(
    .SAMPLE_COUNT(RING_DEPTH)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .rising_edge_i      (rising_edge_i),
    .timestamp_us_i     (timestamp_us_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .position_count_o   (position_count_o),
    .mean_interval_us_o (mean_interval_us_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #(RUN_LIMIT);
    $display("quadrature_decoder_with_interval_average_top test failed");
    $finish;
  end

  // Present one request at a falling edge and hold it until accepted.
  // Entered and left at a falling edge.
  task automatic send_edge(input logic mode, input logic rise, input logic [31:0] ts);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i         <= mode;
    rising_edge_i  <= rise;
    timestamp_us_i <= ts;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_edge(mode, rise, ts);
    if (mode == qdia_pkg::PHASE_A) drv_a = rise;
    else drv_b = rise;
    drv_ts = ts;
    if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
    @(negedge clk_i);
  endtask

  // One quadrature step in the current walking direction
  task automatic send_step(input logic fwd, input logic [31:0] ts);
    if ((drv_a == drv_b) == fwd) send_edge(qdia_pkg::PHASE_B, ~drv_b, ts);
    else send_edge(qdia_pkg::PHASE_A, ~drv_a, ts);
  endtask

  // Random request: mostly legal steps in runs, some repeats and stray edges
  task automatic send_random_edge();
    int unsigned pick;
    logic [31:0] ts;
    pick = $urandom_range(0, 99);
    if (pick < 70) ts = drv_ts + $urandom_range(1, 500);
    else if (pick < 80) ts = drv_ts;
    else if (pick < 90) ts = drv_ts + $urandom_range(0, 32'h000F_FFFF);
    else ts = $urandom;
    if ($urandom_range(0, 19) == 0) walk_fwd = ~walk_fwd;
    if ($urandom_range(0, 99) < 85) send_step(walk_fwd, ts);
    else send_edge(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)), ts);
  endtask

  // Result side: random stall before each result, checked at the accepting edge
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    recv_burst  = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      hold = recv_burst ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      tracker.check_report(position_count_o, mean_interval_us_o);
      if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
      @(negedge clk_i);
    end
  end

  // Reset, directed requests, random requests, drain
  initial begin
    logic [31:0] ts;
    tracker        = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = qdia_pkg::PHASE_A;
    rising_edge_i  = 1'b0;
    timestamp_us_i = '0;
    drv_a          = 1'b0;
    drv_b          = 1'b0;
    drv_ts         = '0;
    walk_fwd       = 1'b1;
    send_burst     = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // First edge measured from time zero, largest interval
    send_edge(qdia_pkg::PHASE_A, 1'b1, 32'hFFFF_FFFF);
    // Timestamp wrap
    send_edge(qdia_pkg::PHASE_B, 1'b1, 32'h0000_0005);
    // Same level again with equal timestamp: no step, zero interval
    send_edge(qdia_pkg::PHASE_B, 1'b1, 32'h0000_0005);
    send_edge(qdia_pkg::PHASE_A, 1'b0, 32'h0000_0010);
    send_edge(qdia_pkg::PHASE_B, 1'b0, 32'h0000_0020);
    // Full cycle the other way
    send_edge(qdia_pkg::PHASE_B, 1'b1, 32'h0000_0030);
    send_edge(qdia_pkg::PHASE_A, 1'b1, 32'h0000_0040);
    send_edge(qdia_pkg::PHASE_B, 1'b0, 32'h0000_0050);
    send_edge(qdia_pkg::PHASE_A, 1'b0, 32'h0000_0060);
    // Repeated falling edge on A
    send_edge(qdia_pkg::PHASE_A, 1'b0, 32'h0000_0070);
    // Fill the ring with the largest interval: mean hits its top value
    ts = 32'h0000_0070;
    for (int i = 0; i < RING_DEPTH; i++) begin
      ts = ts - 32'd1;
      send_step(i[2], ts);
    end

    for (int i = 0; i < 1025; i++) send_random_edge();
    in_valid_i <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("quadrature_decoder_with_interval_average_top test passed");
    end else begin
      $display("quadrature_decoder_with_interval_average_top test failed");
    end
    $finish;
  end

endmodule
